@@ design/cfcr_pkg.sv @@
`default_nettype none

package cfcr_pkg;

  localparam int unsigned LenW = 14;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_PASS   = 3'd1,
    MODE_NORMAL = 3'd2,
    MODE_ONLINE = 3'd3,
    MODE_UPDATE = 3'd4
  } op_mode_e;

  localparam logic [15:0] CrcPoly = 16'h1021;
  localparam logic [15:0] CrcInit = 16'hFFFF;

  localparam logic [6:0] CmdPass   = 7'h0B;
  localparam logic [6:0] CmdNormal = 7'h0F;
  localparam logic [6:0] CmdOnline = 7'h1F;
  localparam logic [6:0] CmdUpdate = 7'h71;
  localparam logic [7:0] CmdPassAck = 8'h0B;
  localparam logic [7:0] CmdToIdle  = 8'h1B;
  localparam logic [7:0] CmdLocalN  = 8'h0F;
  localparam logic [7:0] CmdLocalO  = 8'h1F;

  localparam logic [LenW-1:0] LenCmd    = 14'd2;
  localparam logic [LenW-1:0] LenUpdate = 14'd6;
  localparam logic [LenW-1:0] LenMinLong = 14'd3;

  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
    logic       frame_first;
  } in_item_t;

  typedef struct packed {
    logic       ack_valid;
    logic [7:0] ack_cmd;
    logic       ack_error;
    logic       forward_frame;
    logic       crc_error;
    op_mode_e   new_mode;
  } out_item_t;

  // msb-first crc-16 step over one byte
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  // update-mode key bytes at frame positions 2..5
  function automatic logic [7:0] magic_byte(input logic [1:0] sel);
    logic [7:0] m;
    unique case (sel)
      2'd0:    m = 8'hA0;
      2'd1:    m = 8'hA0;
      2'd2:    m = 8'h50;
      default: m = 8'h50;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

@@ design/cfcr_if.sv @@
`default_nettype none

interface cfcr_in_if;
  logic                valid;
  logic                ready;
  cfcr_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface cfcr_out_if;
  logic                valid;
  logic                ready;
  cfcr_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ design/crc_framed_command_receiver.sv @@
`default_nettype none

// channel | dir | payload                                             | handshake
// in_i    | in  | func, rx_byte, frame_first                          | valid/ready
// out_o   | out | ack_valid, ack_cmd, ack_error, forward_frame,       | valid/ready
//         |     | crc_error, new_mode                                 |
//
// one beat per cycle when not stalled; a result is in the output register in the
// cycle after the beat that completes a frame (or a return request). the crc step
// for a byte is one unrolled 8-bit update between the frame state registers.
// reset (rst_ni low, async) puts the block in idle mode with no frame in progress.
// input is stalled only while a result waits in the output register and out_o.ready
// is low.

module crc_framed_command_receiver (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  cfcr_in_if.sink           in_i,
  cfcr_out_if.source        out_o
);

  localparam int unsigned LenW = cfcr_pkg::LenW;

  cfcr_pkg::op_mode_e mode_q, mode_d;
  logic               active_q, active_d;
  logic [LenW-1:0]    idx_q, idx_d;
  logic [LenW-1:0]    len_q, len_d;
  logic               lh_q, lh_d;
  logic [7:0]         cmd_q, cmd_d;
  logic [15:0]        crc_q, crc_d;
  logic [7:0]         h0_q, h0_d, h1_q, h1_d;
  logic               magic_q, magic_d;

  logic                out_vld_q, out_vld_d;
  cfcr_pkg::out_item_t out_q, out_d;

  logic accept;
  logic res_vld;
  cfcr_pkg::out_item_t res;

  // frame state as seen by this beat (a first byte restarts everything)
  logic            e_act, e_lh, e_magic;
  logic [LenW-1:0] e_idx, e_len;
  logic [7:0]      e_cmd, e_h0, e_h1;
  logic [15:0]     e_crc, fin;
  logic            len_known, done, crc_bad;
  logic [7:0]      b;
  logic [1:0]      msel;

  assign in_i.ready  = !out_vld_q || out_o.ready;
  assign accept      = in_i.valid && in_i.ready;
  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

  always_comb begin
    logic first;
    first   = in_i.data.frame_first;
    b       = in_i.data.rx_byte;
    e_act   = first || active_q;
    e_idx   = first ? '0 : idx_q;
    e_len   = first ? '0 : len_q;
    e_lh    = first ? 1'b0 : lh_q;
    e_cmd   = first ? 8'h00 : cmd_q;
    e_crc   = first ? cfcr_pkg::CrcInit : crc_q;
    e_h0    = first ? 8'h00 : h0_q;
    e_h1    = first ? 8'h00 : h1_q;
    e_magic = first ? 1'b1 : magic_q;
    msel    = e_idx[1:0] - 2'd2;

    mode_d   = mode_q;
    active_d = active_q;
    idx_d    = idx_q;
    len_d    = len_q;
    lh_d     = lh_q;
    cmd_d    = cmd_q;
    crc_d    = crc_q;
    h0_d     = h0_q;
    h1_d     = h1_q;
    magic_d  = magic_q;
    res_vld  = 1'b0;
    res      = '0;
    len_known = 1'b0;
    done      = 1'b0;
    fin       = '0;
    crc_bad   = 1'b0;

    if (accept) begin
      if (in_i.data.func) begin
        if (mode_q == cfcr_pkg::MODE_NORMAL || mode_q == cfcr_pkg::MODE_ONLINE) begin
          mode_d  = cfcr_pkg::MODE_IDLE;
          res_vld = 1'b1;
          res.new_mode = cfcr_pkg::MODE_IDLE;
        end
      end else if (e_act) begin
        active_d = 1'b1;
        len_d    = e_len;
        lh_d     = e_lh;
        cmd_d    = e_cmd;
        crc_d    = (e_idx >= LenW'(2)) ? cfcr_pkg::crc_byte(e_crc, e_h0) : e_crc;
        h0_d     = e_h1;
        h1_d     = b;
        magic_d  = e_magic && !(e_idx >= LenW'(2) && e_idx <= LenW'(5) &&
                                b != cfcr_pkg::magic_byte(msel));
        idx_d    = e_idx + LenW'(1);

        if (e_idx == '0) begin
          lh_d = b[7];
          if (b[7]) begin
            len_d = {b[6:0], 7'd0};
          end else begin
            len_d = {7'd0, b[6:0]};
            if (b[6:0] < 7'd2) active_d = 1'b0;
          end
        end else if (e_idx == LenW'(1)) begin
          if (e_lh) begin
            len_d = {e_len[LenW-1:7], b[6:0]};
            if ({e_len[LenW-1:7], b[6:0]} < cfcr_pkg::LenMinLong) active_d = 1'b0;
          end else begin
            cmd_d = b;
          end
        end else if (e_idx == LenW'(2) && e_lh) begin
          cmd_d = b;
        end

        len_known = lh_d ? (e_idx >= LenW'(1)) : 1'b1;
        done      = active_d && len_known && (idx_d == len_d);

        if (done) begin
          active_d = 1'b0;
          fin      = ~crc_d;
          crc_bad  = cmd_d[7] && (fin[15:8] != h0_d || fin[7:0] != h1_d);
          res.new_mode = mode_q;
          priority if (mode_q != cfcr_pkg::MODE_IDLE && mode_q != cfcr_pkg::MODE_PASS) begin
            res_vld = 1'b0;
          end else if (crc_bad) begin
            res_vld = 1'b1;
            res.crc_error = 1'b1;
          end else if (mode_q == cfcr_pkg::MODE_IDLE) begin
            res_vld       = 1'b1;
            res.ack_valid = 1'b1;
            res.ack_cmd   = cmd_d;
            priority if (cmd_d[6:0] == cfcr_pkg::CmdPass && len_d == cfcr_pkg::LenCmd) begin
              mode_d = cfcr_pkg::MODE_PASS;
            end else if (cmd_d[6:0] == cfcr_pkg::CmdNormal && len_d == cfcr_pkg::LenCmd) begin
              mode_d = cfcr_pkg::MODE_NORMAL;
            end else if (cmd_d[6:0] == cfcr_pkg::CmdOnline && len_d == cfcr_pkg::LenCmd) begin
              mode_d = cfcr_pkg::MODE_ONLINE;
            end else if (cmd_d[6:0] == cfcr_pkg::CmdUpdate && len_d == cfcr_pkg::LenUpdate &&
                         magic_d) begin
              mode_d = cfcr_pkg::MODE_UPDATE;
            end else begin
              res.ack_error = 1'b1;
            end
            res.new_mode = mode_d;
          end else begin
            // passthrough: a few commands are handled or dropped here, the rest go across
            priority if (cmd_d == cfcr_pkg::CmdToIdle && len_d == cfcr_pkg::LenCmd) begin
              mode_d        = cfcr_pkg::MODE_IDLE;
              res_vld       = 1'b1;
              res.ack_valid = 1'b1;
              res.ack_cmd   = cmd_d;
              res.new_mode  = cfcr_pkg::MODE_IDLE;
            end else if (cmd_d == cfcr_pkg::CmdPassAck && len_d == cfcr_pkg::LenCmd) begin
              res_vld       = 1'b1;
              res.ack_valid = 1'b1;
              res.ack_cmd   = cmd_d;
            end else if (cmd_d == cfcr_pkg::CmdPassAck || cmd_d == cfcr_pkg::CmdToIdle ||
                         cmd_d == cfcr_pkg::CmdLocalN || cmd_d == cfcr_pkg::CmdLocalO) begin
              res_vld = 1'b0;
            end else begin
              res_vld           = 1'b1;
              res.forward_frame = 1'b1;
            end
          end
        end
      end
    end

    out_vld_d = out_vld_q;
    out_d     = out_q;
    if (out_o.ready) out_vld_d = 1'b0;
    if (res_vld) begin
      out_vld_d = 1'b1;
      out_d     = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= cfcr_pkg::MODE_IDLE;
      active_q  <= 1'b0;
      idx_q     <= '0;
      len_q     <= '0;
      lh_q      <= 1'b0;
      cmd_q     <= 8'h00;
      crc_q     <= cfcr_pkg::CrcInit;
      h0_q      <= 8'h00;
      h1_q      <= 8'h00;
      magic_q   <= 1'b1;
      out_vld_q <= 1'b0;
    end else begin
      mode_q    <= mode_d;
      active_q  <= active_d;
      idx_q     <= idx_d;
      len_q     <= len_d;
      lh_q      <= lh_d;
      cmd_q     <= cmd_d;
      crc_q     <= crc_d;
      h0_q      <= h0_d;
      h1_q      <= h1_d;
      magic_q   <= magic_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

endmodule

`default_nettype wire
